### design/tgr_pkg.sv
// shared constants, types and register codes for the text glyph rasterizer
// no dependencies; imported by every module of the block
package tgr_pkg;

   localparam int GlyphCountDefault = 256;
   localparam int GlyphRowsDefault  = 16;
   localparam int AddrBitsDefault   = 20;

   // font store rows are laid out at a fixed pitch of 16 per character
   localparam int RowPitch    = 16;
   localparam int RowIdxBits  = 4;
   localparam int SlotBits    = 12;
   localparam int CodeBits    = 8;
   localparam int CsrIdxBits  = 2;
   localparam int CsrDataBits = 13;
   localparam int WidthBits   = 13;
   localparam int OriginBits  = 12;
   localparam int ColorBits   = 8;
   localparam int OutColBits  = 5;
   localparam int ColBits     = 10;
   localparam int LineBits    = 12;
   localparam int AddrOutBits = 20;
   localparam int MaskBits    = 8;
   localparam int XBits       = 14;
   localparam int YBaseBits   = 13;
   localparam int YBits       = 14;
   localparam int ProdBits    = 27;
   localparam int SumBits     = 28;
   localparam int ReqDataBits = 24;
   localparam int RspDataBits = 40;
   localparam int RspPadBits  = RspDataBits - OutColBits - MaskBits - AddrOutBits;

   localparam logic [CodeBits-1:0]  CharEnd     = 8'h00;
   localparam logic [CodeBits-1:0]  CharTab     = 8'h09;
   localparam logic [CodeBits-1:0]  CharNewline = 8'h0A;
   localparam logic [ColorBits-1:0] MaxColor    = 8'd16;
   localparam logic [LineBits-1:0]  LineStep    = 12'd16;

   localparam logic [WidthBits-1:0] ScreenWidthReset = 13'd320;
   localparam logic [ColorBits-1:0] PenColorReset    = 8'd7;

   typedef enum logic [CsrIdxBits-1:0] {
      CsrScreenWidth = 2'd0,
      CsrOriginX     = 2'd1,
      CsrOriginY     = 2'd2,
      CsrPenColor    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                  load;
      logic                  home;
      logic                  tab;
      logic                  newline;
      logic                  start_char;
      logic                  issue;
      logic                  last;
      logic [RowIdxBits-1:0] row;
   } tgr_cmd_type;

   typedef struct packed {
      logic pipe_en;
      logic pen_ok;
   } tgr_status_type;

endpackage

### design/tgr_ctrl.sv
// controller: decodes requests and sequences the glyph rows of a character
// depends on tgr_pkg
module tgr_ctrl import tgr_pkg::*; #(
   parameter int GLYPH_ROWS = GlyphRowsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,
   input  logic [ReqDataBits-1:0] req_tdata,
   output tgr_cmd_type            cmd,
   input  tgr_status_type         status
);

   localparam int RowBits = $clog2(GLYPH_ROWS);
   localparam logic [RowBits-1:0] LastRow = RowBits'(GLYPH_ROWS - 1);

   typedef enum logic [1:0] {
      StIdle = 2'b01,
      StRows = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [RowBits-1:0]   row_ff, row_in;
   logic                 accept;
   logic                 is_text;
   logic [CodeBits-1:0]  code;
   logic                 printable;

   assign req_tready = (state_ff == StIdle);
   assign accept     = req_tvalid && req_tready;
   assign is_text    = req_tuser;
   assign code       = req_tdata[SlotBits +: CodeBits];
   assign printable  = accept && is_text && (code != CharEnd) && (code != CharTab)
                       && (code != CharNewline);

   always_comb begin
      cmd            = '0;
      cmd.load       = accept && !is_text;
      cmd.home       = accept && is_text && (code == CharEnd);
      cmd.tab        = accept && is_text && (code == CharTab);
      cmd.newline    = accept && is_text && (code == CharNewline);
      cmd.start_char = printable;
      cmd.row        = RowIdxBits'(row_ff);
      cmd.last       = (row_ff == LastRow);
      state_in       = state_ff;
      row_in         = row_ff;
      case (state_ff)
         StIdle: begin
            // a suppressed colour still moves the cursor but draws nothing
            if (printable && status.pen_ok) begin
               state_in = StRows;
               row_in   = '0;
            end
         end
         StRows: begin
            if (status.pipe_en) begin
               cmd.issue = 1'b1;
               if (row_ff == LastRow) begin
                  state_in = StIdle;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
      end
   end

endmodule

### design/tgr_datapath.sv
// datapath: registers, cursor, font store and the two-stage row pipeline
// depends on tgr_pkg
module tgr_datapath import tgr_pkg::*; #(
   parameter int GLYPH_COUNT = GlyphCountDefault,
   parameter int ADDR_BITS   = AddrBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxBits-1:0]  csr_index,
   input  logic [CsrDataBits-1:0] csr_data,
   input  logic [ReqDataBits-1:0] req_tdata,
   input  tgr_cmd_type            cmd,
   output tgr_status_type         status,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RspDataBits-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   localparam int StoreDepth = GLYPH_COUNT * RowPitch;
   localparam int IdxBits    = $clog2(StoreDepth);
   localparam logic [SumBits-1:0] AddrMask = SumBits'((64'd1 << ADDR_BITS) - 64'd1);

   logic [WidthBits-1:0]  screen_width_ff;
   logic [OriginBits-1:0] origin_x_ff;
   logic [OriginBits-1:0] origin_y_ff;
   logic [ColorBits-1:0]  pen_color_ff;

   logic [ColBits-1:0]    cursor_ff;
   logic [LineBits-1:0]   line_ff;
   logic [CodeBits-1:0]   code_ff;
   logic [XBits-1:0]      x_ff;
   logic [YBaseBits-1:0]  ybase_ff;

   logic [MaskBits-1:0]   store_mem [StoreDepth];
   logic [MaskBits-1:0]   rd_ff;
   logic [SlotBits-1:0]   slot;
   logic [CodeBits-1:0]   din;
   logic [SlotBits-1:0]   full_idx;
   logic [IdxBits-1:0]    rd_idx;
   logic                  blank;

   logic                  pipe_en;
   logic                  v1_ff;
   logic                  blank1_ff;
   logic                  last1_ff;
   logic [XBits-1:0]      x1_ff;
   logic [ProdBits-1:0]   prod_ff, prod_in;
   logic [YBits-1:0]      y;
   logic [SumBits-1:0]    sum;

   logic                  rsp_valid_ff;
   logic [AddrOutBits-1:0] addr_ff;
   logic [MaskBits-1:0]   mask_ff;
   logic [OutColBits-1:0] color_ff;
   logic                  last_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff <= ScreenWidthReset;
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
         pen_color_ff    <= PenColorReset;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CsrScreenWidth: screen_width_ff <= csr_data[WidthBits-1:0];
            CsrOriginX:     origin_x_ff     <= csr_data[OriginBits-1:0];
            CsrOriginY:     origin_y_ff     <= csr_data[OriginBits-1:0];
            CsrPenColor:    pen_color_ff    <= csr_data[ColorBits-1:0];
            default: begin
            end
         endcase
      end
   end

   // cursor and per-character latches
   assign slot = req_tdata[SlotBits-1:0];
   assign din  = req_tdata[SlotBits +: CodeBits];

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         line_ff   <= '0;
      end else if (cmd.home) begin
         cursor_ff <= '0;
         line_ff   <= '0;
      end else if (cmd.tab) begin
         cursor_ff <= (cursor_ff | ColBits'(3)) + 1'b1;
      end else if (cmd.newline) begin
         cursor_ff <= '0;
         line_ff   <= line_ff + LineStep;
      end else if (cmd.start_char) begin
         cursor_ff <= cursor_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_char) begin
         code_ff  <= din;
         x_ff     <= XBits'(origin_x_ff) + XBits'({cursor_ff, 3'b000});
         ybase_ff <= YBaseBits'(origin_y_ff) + YBaseBits'(line_ff);
      end
   end

   // font store, registered read
   assign full_idx = {code_ff, cmd.row};
   assign rd_idx   = full_idx[IdxBits-1:0];
   assign blank    = ({1'b0, code_ff} >= (CodeBits + 1)'(GLYPH_COUNT));

   always_ff @(posedge clock) begin
      if (cmd.load && ({1'b0, slot} < (SlotBits + 1)'(StoreDepth))) begin
         store_mem[slot[IdxBits-1:0]] <= din;
      end
      if (cmd.issue) begin
         rd_ff <= store_mem[rd_idx];
      end
   end

   // row pipeline: multiply, then add and present; whole pipe stalls together
   // the column term travels with the row so a new character can be taken early
   assign pipe_en = !rsp_valid_ff || rsp_tready;
   assign y       = YBits'(ybase_ff) + YBits'(cmd.row);
   assign prod_in = ProdBits'(y) * ProdBits'(screen_width_ff);
   assign sum     = (SumBits'(prod_ff) + SumBits'(x1_ff)) & AddrMask;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         v1_ff        <= cmd.issue;
         rsp_valid_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         prod_ff   <= prod_in;
         x1_ff     <= x_ff;
         blank1_ff <= blank;
         last1_ff  <= cmd.last;
         addr_ff   <= sum[AddrOutBits-1:0];
         mask_ff   <= blank1_ff ? '0 : rd_ff;
         color_ff  <= pen_color_ff[OutColBits-1:0];
         last_ff   <= last1_ff;
      end
   end

   assign status.pipe_en = pipe_en;
   assign status.pen_ok  = (pen_color_ff <= MaxColor);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RspPadBits{1'b0}}, color_ff, mask_ff, addr_ff};
   assign rsp_tlast  = last_ff;

endmodule

### design/text_glyph_rasterizer_core.sv
// top level of the text glyph rasterizer: controller plus datapath
// depends on tgr_pkg, tgr_ctrl, tgr_datapath
//
//   channel | dir | handshake          | payload
//   req     | in  | req_tvalid/tready  | tuser command, tdata font_slot, data_byte
//   rsp     | out | rsp_tvalid/tready  | tdata address, mask, color; tlast last row
//   csr     | in  | csr_valid/ready    | csr_index, csr_data
//
// loads and cursor bytes leave req ready; a drawn character issues one
// font store read per row, and each issued row is registered through a
// multiply stage, then an add stage.
// a stalled rsp freezes the row pipeline; req is accepted again once the
// last row is issued. synchronous active-high reset clears control,
// csr and cursor state; the font store and data registers are not cleared.
module text_glyph_rasterizer_core import tgr_pkg::*; #(
   parameter int GLYPH_COUNT = GlyphCountDefault,
   parameter int GLYPH_ROWS  = GlyphRowsDefault,
   parameter int ADDR_BITS   = AddrBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,   // [0] command
   input  logic [ReqDataBits-1:0] req_tdata,   // [11:0] font_slot, [19:12] data_byte
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RspDataBits-1:0] rsp_tdata,   // [19:0] pixel_address, [27:20] pixel_mask,
                                               // [32:28] write_color
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxBits-1:0]  csr_index,
   input  logic [CsrDataBits-1:0] csr_data
);

   tgr_cmd_type    cmd;
   tgr_status_type status;

   tgr_ctrl #(
      .GLYPH_ROWS (GLYPH_ROWS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status)
   );

   tgr_datapath #(
      .GLYPH_COUNT (GLYPH_COUNT),
      .ADDR_BITS   (ADDR_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### design/tgr_checker.sv
// port-level checks for the text glyph rasterizer, bound to the top level
// depends on tgr_pkg and text_glyph_rasterizer_core
module tgr_checker import tgr_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RspDataBits-1:0] rsp_tdata,
   input logic                   rsp_tlast
);

   // a stalled row holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // the block only becomes busy because a request was taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid))
      else $error("req_tready fell without an accepted request");

   // rows of one glyph follow each other without gaps
   a_rows_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a glyph");

   // suppressed colors never reach the output
   a_color_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[32:28] <= 5'd16)
      else $error("color above sixteen emitted");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind text_glyph_rasterizer_core tgr_checker u_tgr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
